// File: hw/rtl/pdat_pkg.sv
// shared types, codes and constants for the proximity point table
`default_nettype none
package pdat_pkg;

    localparam int PDAT_TABLE_DEPTH = 16;
    localparam int PDAT_QDEPTH      = 2;
    localparam int PDAT_PADDR_W     = 3;
    localparam logic [31:0] PDAT_AGE_THR_RST = 32'd10000;

    // op field codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_PURGE  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // command kinds after classification
    localparam logic [1:0] K_ADD    = 2'd0;
    localparam logic [1:0] K_PURGE  = 2'd1;
    localparam logic [1:0] K_REMOVE = 2'd2;
    localparam logic [1:0] K_NOP    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_EVICT_ADD = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_DONE      = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    // register indexes
    localparam logic REG_AGE_THR = 1'b0;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [29:0]        r2;
        logic [31:0]        travelled;
        logic [3:0]         slot;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        seen;
    } t_entry;

endpackage
`default_nettype wire

// File: hw/rtl/pdat_front.sv
// front end: command accept, classification and the command queue
`default_nettype none
module pdat_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [14:0]        i_match_radius,
    input  wire logic [31:0]        i_travelled,
    input  wire logic [3:0]         i_slot_index,
    output logic                    o_busy,
    output logic                    o_cmd_valid,
    output pdat_pkg::t_cmd          o_cmd,
    input  wire logic               i_cmd_pop
);
    import pdat_pkg::*;

    localparam int QPW = (PDAT_QDEPTH > 1) ? $clog2(PDAT_QDEPTH) : 1;
    localparam int QCW = $clog2(PDAT_QDEPTH + 1);

    t_cmd           r_q [PDAT_QDEPTH];
    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_fill, n_fill;
    logic           push;
    t_cmd           cls;

    always_comb begin
        cls.pos_x     = i_pos_x;
        cls.pos_y     = i_pos_y;
        cls.r2        = {15'b0, i_match_radius} * {15'b0, i_match_radius};
        cls.travelled = i_travelled;
        cls.slot      = i_slot_index;
        case (i_op)
            OP_ADD:    cls.kind = K_ADD;
            OP_PURGE:  cls.kind = K_PURGE;
            OP_REMOVE: cls.kind = K_REMOVE;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign o_busy      = (r_fill == QCW'(PDAT_QDEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPW'(PDAT_QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == QPW'(PDAT_QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pdat_back.sv
// back end: point table memory, distance scan, purge and remove sequencer
`default_nettype none
module pdat_back #(
    parameter int TABLE_DEPTH = pdat_pkg::PDAT_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_age_thr,
    input  wire logic        i_cmd_valid,
    input  wire pdat_pkg::t_cmd i_cmd,
    output logic             o_cmd_pop,
    output logic             o_result_valid,
    output logic [2:0]       o_status,
    output logic [4:0]       o_entry_count,
    output logic [4:0]       o_removed_count
);
    import pdat_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (CW > 4) ? CW : 4;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVRD = 4'd1;
    localparam logic [3:0] S_EVWR = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_RMRD = 4'd4;
    localparam logic [3:0] S_RMWR = 4'd5;
    localparam logic [3:0] S_PRD  = 4'd6;
    localparam logic [3:0] S_PCHK = 4'd7;
    localparam logic [3:0] S_PMV  = 4'd8;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_removed, n_removed;
    logic          r_evicted, n_evicted;
    logic          r_s1v, n_s1v;
    logic          r_s2v, n_s2v;
    t_cmd          r_cmd, n_cmd;
    logic [31:0]   r_sqx, r_sqy;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [4:0]    r_out_count;
    logic [4:0]    r_out_removed;

    logic [CW-1:0]      last;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_entry             wr_data;
    logic               finish;
    logic [2:0]         fin_status;
    logic signed [16:0] dx, dy;
    logic signed [33:0] px2, py2;
    logic [32:0]        d2;
    logic               issue;
    logic               hit;
    logic [31:0]        age;

    assign last = r_cnt - CW'(1);
    assign dx   = {r_rd_data.x[15], r_rd_data.x} - {r_cmd.pos_x[15], r_cmd.pos_x};
    assign dy   = {r_rd_data.y[15], r_rd_data.y} - {r_cmd.pos_y[15], r_cmd.pos_y};
    assign px2  = dx * dx;
    assign py2  = dy * dy;
    assign d2   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign issue = (r_idx < r_cnt);
    assign hit  = r_s2v && (d2 <= {3'b000, r_cmd.r2});
    assign age  = r_cmd.travelled - r_rd_data.seen;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_removed  = r_removed;
        n_evicted  = r_evicted;
        n_cmd      = r_cmd;
        n_s1v      = 1'b0;
        n_s2v      = 1'b0;
        rd_addr    = r_idx[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_idx[IW-1:0];
        wr_data    = r_rd_data;
        o_cmd_pop  = 1'b0;
        finish     = 1'b0;
        fin_status = ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_removed = '0;
                    n_evicted = 1'b0;
                    n_idx     = '0;
                    case (i_cmd.kind)
                        K_ADD: begin
                            n_state = (r_cnt == CW'(TABLE_DEPTH)) ? S_EVRD : S_SCAN;
                        end
                        K_PURGE: begin
                            n_state = S_PRD;
                        end
                        K_REMOVE: begin
                            if (SW'(i_cmd.slot) < SW'(r_cnt)) begin
                                n_idx   = CW'(i_cmd.slot);
                                n_state = S_RMRD;
                            end else begin
                                finish     = 1'b1;
                                fin_status = ST_BAD_INDEX;
                            end
                        end
                        default: begin
                            finish     = 1'b1;
                            fin_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_EVRD: begin
                rd_addr = last[IW-1:0];
                n_state = S_EVWR;
            end
            S_EVWR: begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                n_cnt     = last;
                n_evicted = 1'b1;
                n_removed = CW'(1);
                n_idx     = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (hit) begin
                    finish     = 1'b1;
                    fin_status = ST_DUP;
                    n_state    = S_IDLE;
                end else if (!issue && !r_s1v && !r_s2v) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_cnt[IW-1:0];
                    wr_data.x    = r_cmd.pos_x;
                    wr_data.y    = r_cmd.pos_y;
                    wr_data.seen = r_cmd.travelled;
                    n_cnt        = r_cnt + CW'(1);
                    finish       = 1'b1;
                    fin_status   = r_evicted ? ST_EVICT_ADD : ST_ADDED;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = issue ? r_idx + CW'(1) : r_idx;
                    n_s1v = issue;
                    n_s2v = r_s1v;
                end
            end
            S_RMRD: begin
                rd_addr = last[IW-1:0];
                n_state = S_RMWR;
            end
            S_RMWR: begin
                wr_en      = 1'b1;
                n_cnt      = last;
                n_removed  = CW'(1);
                finish     = 1'b1;
                fin_status = ST_DONE;
                n_state    = S_IDLE;
            end
            S_PRD: begin
                if (issue) begin
                    n_state = S_PCHK;
                end else begin
                    finish     = 1'b1;
                    fin_status = ST_DONE;
                    n_state    = S_IDLE;
                end
            end
            S_PCHK: begin
                if (age > i_age_thr) begin
                    rd_addr = last[IW-1:0];
                    n_state = S_PMV;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_PRD;
                end
            end
            S_PMV: begin
                wr_en     = 1'b1;
                n_cnt     = last;
                n_removed = r_removed + CW'(1);
                n_state   = S_PRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (finish) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_removed   <= '0;
            r_evicted   <= 1'b0;
            r_s1v       <= 1'b0;
            r_s2v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_removed   <= n_removed;
            r_evicted   <= n_evicted;
            r_s1v       <= n_s1v;
            r_s2v       <= n_s2v;
            r_out_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_sqx <= px2[31:0];
        r_sqy <= py2[31:0];
        if (finish) begin
            r_out_status  <= fin_status;
            r_out_count   <= 5'(n_cnt);
            r_out_removed <= 5'(n_removed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_result_valid  = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;
    assign o_removed_count = r_out_removed;

endmodule
`default_nettype wire

// File: hw/rtl/proximity_dedup_aging_table.sv
// top level: register port, command front end and table back end
//
//   channel   handshake                      payload
//   command   start in, busy out              i_op, i_pos_x, i_pos_y, i_match_radius,
//                                             i_travelled, i_slot_index
//   result    o_result_valid strobe          o_status, o_entry_count, o_removed_count
//   config    psel/penable/pwrite, pready    paddr, pwdata, prdata
//
// add: the command is popped, a full table first evicts in a read and a write step, then the
// scan streams one entry per cycle through a registered read and a registered squaring stage
// purge: each entry is read and its age checked, a dropped entry is replaced by the last one;
// remove: the last entry is read, then written into the removed slot
// a two-entry command queue lets start transfers go in while the table works
// reset clears the entry count, queue and age threshold (10000)
// the result strobe lasts one cycle; the receiver cannot stall it
`default_nettype none
module proximity_dedup_aging_table #(
    parameter int TABLE_DEPTH = pdat_pkg::PDAT_TABLE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_op,
    input  wire logic signed [15:0]                i_pos_x,
    input  wire logic signed [15:0]                i_pos_y,
    input  wire logic [14:0]                       i_match_radius,
    input  wire logic [31:0]                       i_travelled,
    input  wire logic [3:0]                        i_slot_index,
    output logic                                   o_result_valid,
    output logic [2:0]                             o_status,
    output logic [4:0]                             o_entry_count,
    output logic [4:0]                             o_removed_count,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pdat_pkg::PDAT_PADDR_W-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import pdat_pkg::*;

    logic [31:0] r_age_thr;
    logic        reg_hit;
    logic        cmd_valid;
    logic        cmd_pop;
    t_cmd        cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PDAT_PADDR_W-1] == REG_AGE_THR);
    assign prdata  = reg_hit ? r_age_thr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_thr <= PDAT_AGE_THR_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_age_thr <= pwdata;
        end
    end

    pdat_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_match_radius (i_match_radius),
        .i_travelled    (i_travelled),
        .i_slot_index   (i_slot_index),
        .o_busy         (busy),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    pdat_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_age_thr       (r_age_thr),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_removed_count (o_removed_count)
    );

endmodule
`default_nettype wire
